// ===== rtl/core/cccd_write_table_assert.svh =====
// Assertion macros shared by the table blocks; clk and rst must be in scope.
`ifndef CCCD_WRITE_TABLE_ASSERT_SVH
`define CCCD_WRITE_TABLE_ASSERT_SVH

// Same-cycle implication.
`define CCCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cccd assertion failed");

// Next-cycle implication.
`define CCCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cccd assertion failed");

`endif

// ===== rtl/core/cccd_pkg.sv =====
package cccd_pkg;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_OFFSET  = 3'd1;
  localparam logic [2:0] ST_BAD_LENGTH  = 3'd2;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL  = 3'd4;

  localparam logic [15:0] FREE_KEY     = 16'hFFFF;
  localparam logic [9:0]  REQ_LENGTH   = 10'd2;
  localparam int          CMD_Q_DEPTH  = 2;

  typedef struct packed {
    logic [15:0] conn_handle;
    logic [15:0] new_value;
    logic [9:0]  write_length;
    logic [9:0]  write_offset;
    logic [15:0] allowed_bits;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       stored_changed;
  } rsp_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic [15:0] conn_handle;
    logic [15:0] new_value;
    logic [2:0]  status;
  } cmd_t;

  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  value;
  } entry_t;

endpackage

// ===== rtl/core/cccd_front.sv =====
module cccd_front (
  input  logic           push,
  output logic           full,
  input  cccd_pkg::req_t req,
  input  logic           q_full,
  output logic           cmd_wr,
  output cccd_pkg::cmd_t cmd
);
  import cccd_pkg::*;

  assign full   = q_full;
  assign cmd_wr = push & ~q_full;

  // Checks run in priority order: offset, length, then mask.
  always_comb begin
    cmd.conn_handle = req.conn_handle;
    cmd.new_value   = req.new_value;
    if (req.write_offset != 10'd0) begin
      cmd.status = ST_BAD_OFFSET;
    end else if (req.write_length != REQ_LENGTH) begin
      cmd.status = ST_BAD_LENGTH;
    end else if ((req.new_value & ~req.allowed_bits) != 16'd0) begin
      cmd.status = ST_UNSUPPORTED;
    end else begin
      cmd.status = ST_OK;
    end
  end

endmodule

// ===== rtl/core/cccd_cmd_q.sv =====
`include "cccd_write_table_assert.svh"

module cccd_cmd_q (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  cccd_pkg::cmd_t wr_data,
  input  logic           rd,
  output cccd_pkg::cmd_t rd_data,
  output logic           q_full,
  output logic           q_empty
);
  import cccd_pkg::*;

  localparam int PTR_W = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_Q_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CMD_Q_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CMD_Q_DEPTH - 1);

  cmd_t             slots [CMD_Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (count == FULL_CNT);
  assign q_empty = (count == '0);
  assign do_wr   = wr & ~q_full;
  assign do_rd   = rd & ~q_empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `CCCD_ASSERT_NOW(a_q_no_overflow, wr, !q_full)
  `CCCD_ASSERT_NEXT(a_q_fill, do_wr && !do_rd, count == $past(count) + 1'b1)
  `CCCD_ASSERT_NEXT(a_q_drain, do_rd && !do_wr, count == $past(count) - 1'b1)

endmodule

// ===== rtl/core/cccd_back.sv =====
`include "cccd_write_table_assert.svh"

module cccd_back #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  cccd_pkg::cmd_t q_data,
  output logic           q_rd,
  output logic           empty,
  input  logic           pop,
  output cccd_pkg::rsp_t rsp
);
  import cccd_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] END_CNT  = CNT_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t           state;
  cmd_t             cur;
  logic [CNT_W-1:0] issue_cnt;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;
  entry_t           rd_ent;
  logic             rd_vld;
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic [7:0]       hit_val;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  rsp_t             res;
  logic             out_valid;
  rsp_t             out_data;

  entry_t           mem [TABLE_ENTRIES];
  logic             ent_valid [TABLE_ENTRIES];

  logic             issue;
  logic             pop_ok;
  logic             out_load;
  logic [15:0]      key_eff;
  logic [7:0]       val_eff;
  logic [15:0]      stored;
  logic             differs;
  logic             mem_we;
  logic [IDX_W-1:0] widx;

  assign q_rd     = (state == S_IDLE) & ~q_empty;
  assign issue    = (state == S_SCAN) & (issue_cnt != END_CNT);
  assign pop_ok   = pop & out_valid;
  assign out_load = (state == S_RESULT) & (~out_valid | pop);
  assign empty    = ~out_valid;
  assign rsp      = out_data;

  // A slot never written reads as free with a zero byte.
  assign key_eff = rd_vld ? rd_ent.key : FREE_KEY;
  assign val_eff = rd_vld ? rd_ent.value : 8'h00;

  assign stored  = hit_found ? {8'h00, hit_val} : 16'h0000;
  assign differs = (cur.new_value != stored);
  assign mem_we  = (state == S_DECIDE) & differs & (hit_found | free_found);
  assign widx    = hit_found ? hit_idx : free_idx;

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_ent <= mem[issue_cnt[IDX_W-1:0]];
      rd_vld <= ent_valid[issue_cnt[IDX_W-1:0]];
    end
    if (mem_we) begin
      mem[widx] <= '{key: cur.conn_handle, value: cur.new_value[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        ent_valid[i] <= 1'b0;
      end
    end else if (mem_we) begin
      ent_valid[widx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_pend    <= 1'b0;
      issue_cnt  <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (pop_ok) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur        <= q_data;
            issue_cnt  <= '0;
            rd_pend    <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            if (q_data.status != ST_OK) begin
              res   <= '{status: q_data.status, stored_changed: 1'b0};
              state <= S_RESULT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_pend <= issue;
          if (issue) begin
            rd_idx    <= issue_cnt[IDX_W-1:0];
            issue_cnt <= issue_cnt + 1'b1;
          end
          // Keep the lowest matching and lowest free slot.
          if (rd_pend) begin
            if (!hit_found && key_eff == cur.conn_handle) begin
              hit_found <= 1'b1;
              hit_idx   <= rd_idx;
              hit_val   <= val_eff;
            end
            if (!free_found && key_eff == FREE_KEY) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
            if (rd_idx == LAST_IDX) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          res.stored_changed <= mem_we;
          res.status <= (differs && !hit_found && !free_found) ? ST_TABLE_FULL : ST_OK;
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CCCD_ASSERT_NOW(a_changed_is_ok, out_valid && out_data.stored_changed,
    out_data.status == ST_OK)
  `CCCD_ASSERT_NEXT(a_write_marks_valid, mem_we, ent_valid[$past(widx)])
  `CCCD_ASSERT_NOW(a_full_means_no_free, state == S_DECIDE && differs && !hit_found,
    free_found || !mem_we)

endmodule

// ===== rtl/core/cccd_write_table.sv =====
// Descriptor write handler: each accepted request yields exactly one result,
// in order. Requests with a nonzero offset, a length other than two or value
// bits outside the supported mask are refused at once, without a table scan.
// A request that passes is looked up in a table of TABLE_ENTRIES connection
// slots, read one slot a cycle from a single-port array. The table is free
// after reset, with no clearing pass: a per-slot valid bit marks written
// slots. A two-entry command queue sits between the input checks and the
// table engine, and a result register holds the answer while the next
// request is taken in.
module cccd_write_table #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  cccd_pkg::req_t req,
  output logic           empty,
  input  logic           pop,
  output cccd_pkg::rsp_t rsp
);
  import cccd_pkg::*;

  logic cmd_wr;
  cmd_t cmd;
  logic q_full;
  logic q_empty;
  logic q_rd;
  cmd_t q_data;

  cccd_front u_front (
    .push   (push),
    .full   (full),
    .req    (req),
    .q_full (q_full),
    .cmd_wr (cmd_wr),
    .cmd    (cmd)
  );

  cccd_cmd_q u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_wr),
    .wr_data (cmd),
    .rd      (q_rd),
    .rd_data (q_data),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  cccd_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .rsp     (rsp)
  );

endmodule
